// ===== hw/rtl/lbm_pkg.sv =====
package lbm_pkg;

  localparam int DataW        = 32;
  localparam int CfgW         = 31;
  localparam int FracBitsDflt = 24;
  localparam int QueueDepth   = 4;

  localparam logic [1:0] KindFluid     = 2'd0;
  localparam logic [1:0] KindSolid     = 2'd1;
  localparam logic [1:0] KindEmpty     = 2'd2;
  localparam logic [1:0] KindInterface = 2'd3;

  typedef struct packed {
    logic signed [DataW-1:0] f_rest;
    logic signed [DataW-1:0] f_east;
    logic signed [DataW-1:0] f_north;
    logic signed [DataW-1:0] f_west;
    logic signed [DataW-1:0] f_south;
    logic signed [DataW-1:0] f_northeast;
    logic signed [DataW-1:0] f_northwest;
    logic signed [DataW-1:0] f_southwest;
    logic signed [DataW-1:0] f_southeast;
    logic signed [DataW-1:0] force_x;
    logic signed [DataW-1:0] force_y;
    logic [2:0]              cell_tag;
  } cell_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] density;
    logic signed [DataW-1:0] velocity_x;
    logic signed [DataW-1:0] velocity_y;
    logic                    last_cell;
  } cell_out_t;

  // Work item handed from the front end to the divider back end.
  // Numerators are 2*momentum + force, at most 37 bits signed.
  typedef struct packed {
    logic signed [DataW-1:0] density;
    logic                    do_div;
    logic                    last_cell;
    logic signed [36:0]      num_x;
    logic signed [36:0]      num_y;
  } work_t;

endpackage

// ===== hw/rtl/lbm_front.sv =====
module lbm_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  lbm_pkg::cell_in_t       cell_in,
  input  logic [lbm_pkg::CfgW-1:0] min_density,
  output logic                    work_valid,
  output lbm_pkg::work_t          work
);
  import lbm_pkg::*;

  // Stage 1: partial sums. Stage 2: final sums, saturation, classification.
  logic               s1_valid;
  logic               s1_active;
  logic               s1_last;
  logic signed [35:0] s1_sum_a;
  logic signed [35:0] s1_sum_b;
  logic signed [35:0] s1_mx;
  logic signed [35:0] s1_my;
  logic signed [32:0] s1_fx;
  logic signed [32:0] s1_fy;

  logic signed [35:0] sum;
  logic signed [DataW-1:0] rho;
  logic signed [36:0] mx2;
  logic signed [36:0] my2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_active <= (cell_in.cell_tag[1:0] != KindSolid) &&
                 (cell_in.cell_tag[1:0] != KindEmpty);
    s1_last   <= cell_in.cell_tag[2];
    s1_sum_a  <= 36'(cell_in.f_rest) + 36'(cell_in.f_east) + 36'(cell_in.f_north)
               + 36'(cell_in.f_west) + 36'(cell_in.f_south);
    s1_sum_b  <= 36'(cell_in.f_northeast) + 36'(cell_in.f_northwest)
               + 36'(cell_in.f_southwest) + 36'(cell_in.f_southeast);
    s1_mx     <= 36'(cell_in.f_east) - 36'(cell_in.f_west) + 36'(cell_in.f_northeast)
               - 36'(cell_in.f_northwest) - 36'(cell_in.f_southwest)
               + 36'(cell_in.f_southeast);
    s1_my     <= 36'(cell_in.f_north) - 36'(cell_in.f_south) + 36'(cell_in.f_northeast)
               + 36'(cell_in.f_northwest) - 36'(cell_in.f_southwest)
               - 36'(cell_in.f_southeast);
    s1_fx     <= 33'(cell_in.force_x);
    s1_fy     <= 33'(cell_in.force_y);
  end

  always_comb begin
    sum = s1_sum_a + s1_sum_b;
    if (sum > 36'sd2147483647) begin
      rho = 32'sh7fffffff;
    end else if (sum < -36'sd2147483648) begin
      rho = 32'sh80000000;
    end else begin
      rho = sum[31:0];
    end
    mx2 = {s1_mx, 1'b0} + 37'(s1_fx);
    my2 = {s1_my, 1'b0} + 37'(s1_fy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else begin
      work_valid <= s1_valid;
    end
    work.density   <= s1_active ? rho : '0;
    work.do_div    <= s1_active && (rho > $signed({1'b0, min_density}));
    work.last_cell <= s1_last;
    work.num_x     <= mx2;
    work.num_y     <= my2;
  end

endmodule

// ===== hw/rtl/lbm_queue.sv =====
module lbm_queue #(
  parameter int Depth = lbm_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lbm_pkg::work_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output lbm_pkg::work_t pop_data
);
  import lbm_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t         mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop && not_empty) begin
        rd_ptr <= bump(rd_ptr);
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop && not_empty);
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/lbm_back.sv =====
module lbm_back #(
  parameter int FracBits = lbm_pkg::FracBitsDflt
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  lbm_pkg::work_t     work,
  output logic               out_valid,
  output lbm_pkg::cell_out_t result
);
  import lbm_pkg::*;

  // Restoring divider, one quotient bit per stage, both axes side by side.
  // Magnitude numerator is at most 2^36 and is scaled by 2^FracBits; the
  // quotient is kept to QW bits, with a separate flag for overflow.
  localparam int NW     = 37;
  localparam int DW     = 33;
  localparam int QW     = 33;
  localparam int Stages = QW;
  localparam int AW     = NW + FracBits;

  typedef struct packed {
    logic                    valid;
    logic                    do_div;
    logic                    last_cell;
    logic signed [DataW-1:0] density;
    logic [DW-1:0]           den;
    logic                    neg_x;
    logic                    neg_y;
    logic [AW-1:0]           dvd_x;
    logic [AW-1:0]           dvd_y;
    logic [DW:0]             rem_x;
    logic [DW:0]             rem_y;
    logic [QW-1:0]           q_x;
    logic [QW-1:0]           q_y;
    logic                    ovf_x;
    logic                    ovf_y;
  } stage_t;

  stage_t pipe [Stages+1];
  stage_t head;
  logic [NW-1:0] mag_x;
  logic [NW-1:0] mag_y;

  always_comb begin
    mag_x = work.num_x[NW-1] ? NW'(-work.num_x) : NW'(work.num_x);
    mag_y = work.num_y[NW-1] ? NW'(-work.num_y) : NW'(work.num_y);
    head = '0;
    head.valid     = in_valid && !rst;
    head.do_div    = work.do_div;
    head.last_cell = work.last_cell;
    head.density   = work.density;
    head.den       = {work.density, 1'b0};
    head.neg_x     = work.num_x[NW-1];
    head.neg_y     = work.num_y[NW-1];
    head.dvd_x     = {mag_x, {FracBits{1'b0}}};
    head.dvd_y     = {mag_y, {FracBits{1'b0}}};
  end

  // Reduce the dividend's upper bits first: remainder starts from the bits
  // above the QW quotient positions; overflow if they reach the divisor.
  always_ff @(posedge clk) begin
    pipe[0] <= head;
  end

  generate
    for (genvar s = 0; s < Stages; s++) begin : g_div
      stage_t nx;
      logic [DW+1:0] tx;
      logic [DW+1:0] ty;
      always_comb begin
        nx = pipe[s];
        nx.valid = pipe[s].valid && !rst;
        if (s == 0) begin
          // Upper part is handled as a single compare: top bits above
          // the quotient window must be smaller than the divisor.
          nx.rem_x = '0;
          nx.rem_y = '0;
          nx.ovf_x = (pipe[s].dvd_x >> QW) >= (AW)'(pipe[s].den);
          nx.ovf_y = (pipe[s].dvd_y >> QW) >= (AW)'(pipe[s].den);
          nx.rem_x = (DW+1)'(pipe[s].dvd_x >> QW);
          nx.rem_y = (DW+1)'(pipe[s].dvd_y >> QW);
        end
        tx = {nx.rem_x, pipe[s].dvd_x[QW-1-s]};
        ty = {nx.rem_y, pipe[s].dvd_y[QW-1-s]};
        if (tx >= (DW+2)'(pipe[s].den)) begin
          tx = tx - (DW+2)'(pipe[s].den);
          nx.q_x[QW-1-s] = 1'b1;
        end
        if (ty >= (DW+2)'(pipe[s].den)) begin
          ty = ty - (DW+2)'(pipe[s].den);
          nx.q_y[QW-1-s] = 1'b1;
        end
        nx.rem_x = tx[DW:0];
        nx.rem_y = ty[DW:0];
      end
      always_ff @(posedge clk) begin
        pipe[s+1] <= nx;
      end
    end
  endgenerate

  function automatic logic signed [DataW-1:0] finish(
      input logic neg, input logic ovf, input logic [QW-1:0] q);
    logic [QW-1:0] cap;
    logic [QW-1:0] m;
    cap = neg ? QW'(33'h080000000) : QW'(33'h07fffffff);
    m   = (ovf || q > cap) ? cap : q;
    return neg ? DataW'(-m) : DataW'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pipe[Stages].valid;
    end
    result.density    <= pipe[Stages].density;
    result.last_cell  <= pipe[Stages].last_cell;
    result.velocity_x <= pipe[Stages].do_div ?
                         finish(pipe[Stages].neg_x, pipe[Stages].ovf_x, pipe[Stages].q_x) : '0;
    result.velocity_y <= pipe[Stages].do_div ?
                         finish(pipe[Stages].neg_y, pipe[Stages].ovf_y, pipe[Stages].q_y) : '0;
  end

endmodule

// ===== hw/rtl/lbm_d2q9_macroscopic_moments.sv =====
// A start passes through 2 front-end stages, the queue, the divider stages
// and an output register on its way to its done strobe.
// Throughput: one cell per cycle.
// The receiver cannot stall, so busy stays low and results leave in order.
// Synchronous active-high reset clears all valid flags and sets min_density to 0.
module lbm_d2q9_macroscopic_moments #(
  parameter int FRAC_BITS = lbm_pkg::FracBitsDflt
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  lbm_pkg::cell_in_t        cell_in,
  input  logic                     cfg_we,
  input  logic [lbm_pkg::CfgW-1:0] cfg_data,
  output logic                     done,
  output lbm_pkg::cell_out_t       cell_out
);
  import lbm_pkg::*;

  // Velocity threshold; the user writes it only while idle (not enforced).
  logic [CfgW-1:0] min_density;

  logic  work_valid;
  work_t work;
  logic  q_valid;
  work_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_density <= '0;
    end else if (cfg_we) begin
      min_density <= cfg_data;
    end
  end

  // Every stage advances each cycle, so a transaction is never refused.
  assign busy = 1'b0;

  // Front end: sums the distributions, saturates density, decides per cell
  // whether a division is needed, and forms the doubled numerators.
  lbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .cell_in    (cell_in),
    .min_density(min_density),
    .work_valid (work_valid),
    .work       (work)
  );

  // Short queue between the two halves. Since the back end always pops,
  // it holds at most one entry in steady state.
  lbm_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (work_valid),
    .push_data(work),
    .pop      (1'b1),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  // Back end: pipelined restoring divider for both velocity components.
  lbm_back #(.FracBits(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .work     (q_data),
    .out_valid(done),
    .result   (cell_out)
  );

endmodule

// ===== hw/rtl/lbm_checker.sv =====
module lbm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input lbm_pkg::cell_in_t  cell_in,
  input logic               done,
  input lbm_pkg::cell_out_t cell_out
);
  import lbm_pkg::*;

  // Edges from an accepted start to the edge that takes its result.
  localparam int Latency = 38;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_idle_after_reset: assert property (@(posedge clk) $fell(rst) |-> !done)
    else $error("done right after reset");
  a_solid_zero: assert property (@(posedge clk) disable iff (rst)
    done && cell_out.density == '0 |-> cell_out.velocity_x == '0 && cell_out.velocity_y == '0)
    else $error("velocity without density");
  a_nonpos_zero: assert property (@(posedge clk) disable iff (rst)
    done && cell_out.density[DataW-1] |-> cell_out.velocity_x == '0)
    else $error("velocity from negative density");
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##Latency
      done && (cell_out.last_cell == $past(cell_in.cell_tag[2], Latency)))
    else $error("result missing or out of order");

endmodule

bind lbm_d2q9_macroscopic_moments lbm_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cell_in(cell_in),
  .done(done), .cell_out(cell_out)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import lbm_pkg::*;

  localparam int FracBits   = 24;
  localparam int Latency    = 38;
  localparam int NumRandom  = 530;
  localparam longint CycleLimit = 400000;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;

  // Moment calculation for one cell, kept independent of the RTL.
  class moments_scoreboard;
    logic [CfgW-1:0] min_density;
    cell_out_t       pending_moments[$];
    int              mismatch_count;
    int              checked_count;

    function new();
      min_density    = '0;
      mismatch_count = 0;
      checked_count  = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > S32Max) return S32Max;
      if (v < S32Min) return S32Min;
      return v;
    endfunction

    // Quotient num * 2^FracBits / den, truncated toward zero, saturated to 32 bits.
    function longint scaled_quotient(longint num, longint den);
      logic   neg;
      longint mag_num;
      longint q1;
      longint r1;
      longint cap;
      longint mag;
      neg     = num < 0;
      mag_num = neg ? -num : num;
      q1      = mag_num / den;
      r1      = mag_num % den;
      cap     = neg ? 64'sd2147483648 : 64'sd2147483647;
      if (q1 > (64'sd2147483648 >>> FracBits)) begin
        mag = cap;
      end else begin
        mag = (q1 <<< FracBits) + ((r1 <<< FracBits) / den);
        if (mag > cap) mag = cap;
      end
      return neg ? -mag : mag;
    endfunction

    function void note_cell(cell_in_t c);
      cell_out_t r;
      longint    rho;
      longint    mx;
      longint    my;
      logic [1:0] kind;
      kind        = c.cell_tag[1:0];
      r.density   = '0;
      r.velocity_x = '0;
      r.velocity_y = '0;
      r.last_cell = c.cell_tag[2];
      if (kind != KindSolid && kind != KindEmpty) begin
        rho = clamp32(longint'(c.f_rest) + c.f_east + c.f_north + c.f_west + c.f_south
                      + c.f_northeast + c.f_northwest + c.f_southwest + c.f_southeast);
        mx = longint'(c.f_east) - c.f_west + c.f_northeast - c.f_northwest
             - c.f_southwest + c.f_southeast;
        my = longint'(c.f_north) - c.f_south + c.f_northeast + c.f_northwest
             - c.f_southwest - c.f_southeast;
        r.density = rho[31:0];
        if (rho > longint'(min_density)) begin
          r.velocity_x = 32'(scaled_quotient(2 * mx + c.force_x, 2 * rho));
          r.velocity_y = 32'(scaled_quotient(2 * my + c.force_y, 2 * rho));
        end
      end
      pending_moments.push_back(r);
    endfunction

    task check_result(cell_out_t got);
      cell_out_t want;
      if (pending_moments.size() == 0) begin
        report_mismatch("result with no cell outstanding", 0, got.density);
        return;
      end
      want = pending_moments.pop_front();
      checked_count++;
      if (got.density !== want.density)
        report_mismatch("density", want.density, got.density);
      if (got.velocity_x !== want.velocity_x)
        report_mismatch("velocity_x", want.velocity_x, got.velocity_x);
      if (got.velocity_y !== want.velocity_y)
        report_mismatch("velocity_y", want.velocity_y, got.velocity_y);
      if (got.last_cell !== want.last_cell)
        report_mismatch("last_cell", want.last_cell, got.last_cell);
    endtask

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("ERROR at %0t: %s expected %h got %h", $time, what, want, got);
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  cell_in_t        cell_in = '0;
  logic            cfg_we = 1'b0;
  logic [CfgW-1:0] cfg_data = '0;
  logic            done;
  cell_out_t       cell_out;

  moments_scoreboard moments = new();
  longint cycle_count = 0;
  int     idle_percent = 0;
  int     cells_sent = 0;

  always #5 clk = ~clk;

  lbm_d2q9_macroscopic_moments dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cell_in (cell_in),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .done    (done),
    .cell_out(cell_out)
  );

  // The result strobe lasts one cycle and cannot be held off, so every strobe
  // seen at a rising edge is one transaction to check.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) moments.check_result(cell_out);
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("lbm_d2q9_macroscopic_moments: mismatch");
      $finish;
    end
  end

  // Random distribution value. Most draws sit near unit density so the
  // velocity path is exercised; the rest are full-range, extreme or near zero.
  function automatic logic [31:0] rand_dist();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return 32'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  function automatic cell_in_t random_cell();
    cell_in_t c;
    c.f_rest      = rand_dist();
    c.f_east      = rand_dist();
    c.f_north     = rand_dist();
    c.f_west      = rand_dist();
    c.f_south     = rand_dist();
    c.f_northeast = rand_dist();
    c.f_northwest = rand_dist();
    c.f_southwest = rand_dist();
    c.f_southeast = rand_dist();
    c.force_x     = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 65536)) - 32768);
    c.force_y     = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 65536)) - 32768);
    c.cell_tag    = 3'($urandom_range(0, 7));
    return c;
  endfunction

  // Presents one cell, waits for it to be taken, then idles at random.
  // start stays high across back-to-back transactions.
  task automatic send_cell(cell_in_t c);
    start   <= 1'b1;
    cell_in <= c;
    do @(posedge clk); while (busy);
    moments.note_cell(c);
    cells_sent++;
    if ($urandom_range(1, 100) <= idle_percent) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(1, 100) <= idle_percent);
    end
  endtask

  // Stops the sender until every expected result is back, then lets the
  // pipeline drain fully before anything else changes.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (moments.pending_moments.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_min_density(logic [CfgW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    moments.min_density = value;
  endtask

  function automatic cell_in_t uniform_cell(logic [31:0] v, logic [2:0] tag);
    cell_in_t c;
    c = '{v, v, v, v, v, v, v, v, v, 32'h0, 32'h0, tag};
    return c;
  endfunction

  initial begin
    cell_in_t c;
    logic [CfgW-1:0] thresholds[4];
    int phase_idle[4];
    thresholds = '{31'h0, 31'h0100_0000, 31'h7fff_ffff, 31'h0000_0001};
    phase_idle = '{0, 72, 72, 37};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cells: field extremes, every cell kind, both values of the
    // end-of-sweep bit, saturated sums and quotients, zero and negative density.
    for (int k = 0; k < 4; k++) send_cell(uniform_cell(32'h0010_0000, {k[0], k[1:0]}));
    send_cell(uniform_cell(32'h7fff_ffff, 3'b000));
    send_cell(uniform_cell(32'h8000_0000, 3'b100));
    send_cell(uniform_cell(32'h0000_0000, 3'b011));
    send_cell(uniform_cell(32'hffff_ffff, 3'b000));
    send_cell(uniform_cell(32'h0000_0001, 3'b000));
    c = '{32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 3'b000};
    c.f_rest = 32'h0000_0002;
    send_cell(c);
    c = '{32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h8000_0000, 32'h7fff_ffff, 3'b111};
    send_cell(c);
    c = '{32'h0100_0000, 32'h0080_0000, 32'h0, 32'h0, 32'h0080_0000, 32'h0, 32'h0,
          32'h0, 32'h0, 32'hffff_ffff, 32'h0000_0001, 3'b000};
    send_cell(c);
    c = '{32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 32'h0, 3'b000};
    send_cell(c);
    drain();

    // Random phases, each with its own density threshold and an idle rate.
    for (int p = 0; p < 4; p++) begin
      write_min_density(thresholds[p]);
      idle_percent = phase_idle[p];
      for (int n = 0; n < NumRandom / 4; n++) begin
        c = random_cell();
        // A few cells land right at the threshold to test the strict compare.
        if (n % 29 == 0) c = uniform_cell(32'h0, 3'b000);
        if (n % 29 == 0) c.f_rest = {1'b0, thresholds[p]} + $urandom_range(0, 1);
        send_cell(c);
      end
      drain();
    end
    write_min_density('0);
    idle_percent = 0;
    for (int n = 0; n < 20; n++) send_cell(random_cell());
    drain();

    $display("Covered %0d cells over four density thresholds and idle rates 0, 72 and 37%%.",
             cells_sent);
    $display("Checked %0d results with %0d errors.", moments.checked_count,
             moments.mismatch_count);
    if (moments.mismatch_count == 0 && moments.pending_moments.size() == 0) begin
      $display("lbm_d2q9_macroscopic_moments: match");
    end else begin
      $display("lbm_d2q9_macroscopic_moments: mismatch");
    end
    $finish;
  end

endmodule

// ===== lbm_d2q9_macroscopic_moments.f =====
hw/rtl/lbm_pkg.sv
hw/rtl/lbm_front.sv
hw/rtl/lbm_queue.sv
hw/rtl/lbm_back.sv
hw/rtl/lbm_d2q9_macroscopic_moments.sv
hw/rtl/lbm_checker.sv
test/testbench.sv
